// ===== sv/csd_pkg.sv =====
`default_nettype none

package csd_pkg;

  localparam int MAX_ITEMS = 32;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int KEY_W     = 32;
  localparam int TAG_W     = 16;
  localparam int ENTRY_W   = KEY_W + TAG_W;

  // floor(x * 10 / 13) as x * 10 * 631 >> 13, exact for x * 10 below 744
  localparam int SHRINK_NUM   = 10;
  localparam int RECIP_DEN    = 631;
  localparam int RECIP_SHIFT  = 13;
  localparam int SCALED_W     = CNT_W + 4;
  localparam int PROD_W       = SCALED_W + 10;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } entry_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_CMP_RD,
    ST_CMP,
    ST_SWAP,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

  function automatic logic [CNT_W-1:0] shrink(input logic [CNT_W-1:0] g);
    logic [SCALED_W-1:0] scaled;
    logic [PROD_W-1:0]   prod;
    logic [CNT_W-1:0]    q;
    scaled = SCALED_W'(g) * SCALED_W'(SHRINK_NUM);
    prod   = PROD_W'(scaled) * PROD_W'(RECIP_DEN);
    q      = CNT_W'(prod >> RECIP_SHIFT);
    if (q == '0) begin
      q = CNT_W'(1);
    end
    return q;
  endfunction

endpackage

`default_nettype wire

// ===== sv/csd_in_if.sv =====
`default_nettype none

interface csd_in_if import csd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] sort_key;
  logic [TAG_W-1:0]        item_tag;
  logic                    last_item;

  modport source (output valid, sort_key, item_tag, last_item, input ready);
  modport sink   (input valid, sort_key, item_tag, last_item, output ready);
endinterface

`default_nettype wire

// ===== sv/csd_out_if.sv =====
`default_nettype none

interface csd_out_if import csd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] sorted_key;
  logic [TAG_W-1:0]        sorted_tag;
  logic                    end_of_set;
  logic                    overflowed;

  modport source (output valid, sorted_key, sorted_tag, end_of_set, overflowed,
                  input ready);
  modport sink   (input valid, sorted_key, sorted_tag, end_of_set, overflowed,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/csd_ram.sv =====
`default_nettype none

module csd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== sv/csd_ctrl.sv =====
`default_nettype none

module csd_ctrl import csd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  csd_in_if.sink          items,
  csd_out_if.source       results,
  output logic            ram_we,
  output logic [IDX_W-1:0] ram_waddr,
  output entry_t          ram_wdata,
  output logic [IDX_W-1:0] ram_raddr_a,
  output logic [IDX_W-1:0] ram_raddr_b,
  input  wire entry_t     ram_rdata_a,
  input  wire entry_t     ram_rdata_b
);

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] gap, gap_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic             swap_seen, swap_seen_next;
  logic             overflow, overflow_next;
  entry_t           hold, hold_next;
  logic             out_valid;
  entry_t           out_entry;
  logic             out_end, out_ovf;
  logic             out_load;

  logic             in_take;
  logic [CNT_W:0]   partner;
  logic             in_range;
  logic             is_less;
  logic             slot_free;
  logic             emit_last;

  assign in_take   = items.valid && items.ready;
  assign partner   = {1'b0, idx} + {1'b0, gap};
  assign in_range  = partner < {1'b0, count};
  assign is_less   = $signed(ram_rdata_a.key) < $signed(ram_rdata_b.key);
  assign slot_free = !out_valid || results.ready;
  assign emit_last = idx == count - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      gap       <= '0;
      idx       <= '0;
      swap_seen <= 1'b0;
      overflow  <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      gap       <= gap_next;
      idx       <= idx_next;
      swap_seen <= swap_seen_next;
      overflow  <= overflow_next;
    end
    hold <= hold_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    gap_next       = gap;
    idx_next       = idx;
    swap_seen_next = swap_seen;
    overflow_next  = overflow;
    hold_next      = hold;
    items.ready    = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = idx[IDX_W-1:0];
    ram_wdata      = ram_rdata_b;
    ram_raddr_a    = idx[IDX_W-1:0];
    ram_raddr_b    = partner[IDX_W-1:0];
    out_load       = 1'b0;
    unique case (state)
      ST_LOAD: begin
        items.ready = 1'b1;
        ram_waddr   = count[IDX_W-1:0];
        ram_wdata   = '{key: items.sort_key, tag: items.item_tag};
        if (in_take) begin
          if (count < CNT_W'(MAX_ITEMS)) begin
            ram_we     = 1'b1;
            count_next = count + CNT_W'(1);
          end else begin
            overflow_next = 1'b1;
          end
          if (items.last_item) begin
            state_next = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        idx_next       = '0;
        swap_seen_next = 1'b0;
        if (count < CNT_W'(2)) begin
          state_next = ST_EMIT_RD;
        end else begin
          gap_next   = shrink(count);
          state_next = ST_CMP_RD;
        end
      end
      ST_CMP_RD: begin
        if (in_range) begin
          state_next = ST_CMP;
        end else begin
          idx_next       = '0;
          swap_seen_next = 1'b0;
          if (gap <= CNT_W'(1)) begin
            if (!swap_seen) begin
              state_next = ST_EMIT_RD;
            end
          end else begin
            gap_next = shrink(gap);
          end
        end
      end
      ST_CMP: begin
        if (is_less) begin
          ram_we         = 1'b1;
          ram_wdata      = ram_rdata_b;
          hold_next      = ram_rdata_a;
          swap_seen_next = 1'b1;
          state_next     = ST_SWAP;
        end else begin
          idx_next   = idx + CNT_W'(1);
          state_next = ST_CMP_RD;
        end
      end
      ST_SWAP: begin
        ram_we     = 1'b1;
        ram_waddr  = partner[IDX_W-1:0];
        ram_wdata  = hold;
        idx_next   = idx + CNT_W'(1);
        state_next = ST_CMP_RD;
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (emit_last) begin
            count_next    = '0;
            overflow_next = 1'b0;
            idx_next      = '0;
            state_next    = ST_LOAD;
          end else begin
            idx_next   = idx + CNT_W'(1);
            state_next = ST_EMIT_RD;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // output register, frees the input side while the last result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_entry <= ram_rdata_a;
      out_end   <= emit_last;
      out_ovf   <= overflow;
    end
  end

  assign results.valid      = out_valid;
  assign results.sorted_key = out_entry.key;
  assign results.sorted_tag = out_entry.tag;
  assign results.end_of_set = out_end;
  assign results.overflowed = out_ovf;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("item count above capacity");

  a_gap_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP_RD |-> gap != '0 && gap < count)
    else $error("gap out of range during sort");

  a_swap_marks: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWAP |-> swap_seen)
    else $error("swap without swap flag");

  a_set_closes: assert property (@(posedge clk) disable iff (rst)
    out_load && emit_last |=> count == '0 && state == ST_LOAD && out_valid)
    else $error("set not closed after last result");

endmodule

`default_nettype wire

// ===== sv/comb_sort_descending_top.sv =====
`default_nettype none

// Collects a set of signed keys with tags (up to MAX_ITEMS, one cycle per
// transaction; extras are dropped and flagged), sorts them into descending
// order with a comb sort (gap shrinks by 10/13, repeated gap-1 passes until
// no swap) and returns them one transaction each. Key and tag live together
// in one dual-read, single-write RAM: a compare reads in ST_CMP_RD and
// compares in ST_CMP, and a swap adds ST_SWAP for its second write. A set
// of n items takes roughly log(n)/log(1.3) plus a few passes, and each
// result is read in ST_EMIT_RD and loaded in ST_EMIT. Input is taken again
// as soon as the last result of a set sits in the output register.
module comb_sort_descending_top import csd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  csd_in_if.sink    items,
  csd_out_if.source results
);

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr_a;
  logic [IDX_W-1:0] ram_raddr_b;
  entry_t           ram_rdata_a;
  entry_t           ram_rdata_b;

  csd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ITEMS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  csd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .items       (items),
    .results     (results),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr_a (ram_raddr_a),
    .ram_raddr_b (ram_raddr_b),
    .ram_rdata_a (ram_rdata_a),
    .ram_rdata_b (ram_rdata_b)
  );

endmodule

`default_nettype wire
